// ===== src/upd_pkg.sv =====
// Shared types and constants for the URL percent decoder.
`timescale 1ns / 1ps

package upd_pkg;

  // Byte that opens an escape sequence.
  localparam logic [7:0] PERCENT = 8'h25;

  // Codes that an escape may produce; any other code yields no byte.
  localparam int CODE_COUNT = 19;
  localparam logic [7:0] KNOWN_CODES [CODE_COUNT] = '{
    8'h20, 8'h22, 8'h23, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2B, 8'h2C, 8'h2F,
    8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5C, 8'h7C
  };

  // Escape progress, one-hot.
  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_HIGH  = 3'b010,
    PH_LOW   = 3'b100
  } phase_t;

  // One input item as it sits in the input register.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // One result item as it leaves the decode step.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// ===== src/upd_step.sv =====
// Escape state and the per-byte decode logic between input and result registers.
`timescale 1ns / 1ps

module upd_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  upd_pkg::item_t item,
  output upd_pkg::res_t  res
);

  upd_pkg::phase_t phase_r, phase_nxt;
  logic [8:0]      high_r, high_nxt;
  logic [8:0]      digit;
  logic [12:0]     code;
  logic            hit;
  logic [7:0]      hit_code;

  // Digit value: c - 55 from 'A' upward, else c - 48, as 9-bit two's complement.
  assign digit = (item.data >= 8'd65) ? ({1'b0, item.data} - 9'd55)
                                      : ({1'b0, item.data} - 9'd48);

  // Escape code high * 16 + low; the range fits a 13-bit signed word.
  assign code = {high_r, 4'b0000} + {{4{digit[8]}}, digit};

  // Look the code up among the known codes.
  always_comb begin
    hit      = 1'b0;
    hit_code = 8'h00;
    for (int k = 0; k < upd_pkg::CODE_COUNT; k++) begin
      if (code == {5'b00000, upd_pkg::KNOWN_CODES[k]}) begin
        hit      = 1'b1;
        hit_code = upd_pkg::KNOWN_CODES[k];
      end
    end
  end

  // Result and next state for the byte in the input register.
  always_comb begin
    phase_nxt = upd_pkg::PH_PLAIN;
    high_nxt  = high_r;
    res.valid = 1'b0;
    res.data  = 8'h00;
    res.last  = item.last;
    unique case (phase_r)
      upd_pkg::PH_HIGH: begin
        high_nxt  = digit;
        phase_nxt = upd_pkg::PH_LOW;
      end
      upd_pkg::PH_LOW: begin
        res.valid = hit;
        res.data  = hit_code;
      end
      default: begin
        if (item.data == upd_pkg::PERCENT) begin
          phase_nxt = upd_pkg::PH_HIGH;
        end else begin
          res.valid = 1'b1;
          res.data  = item.data;
        end
      end
    endcase
    // The end of the string drops any unfinished escape.
    if (item.last) begin
      phase_nxt = upd_pkg::PH_PLAIN;
    end
  end

  // State advances only when the item moves on to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upd_pkg::PH_PLAIN;
      high_r  <= 9'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      high_r  <= high_nxt;
    end
  end

  // The phase register always holds exactly one hot bit.
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("escape phase is not one-hot");

  // A final byte always leaves the decoder in plain mode.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.last |=> phase_r == upd_pkg::PH_PLAIN)
    else $error("escape state survived the end of the string");

  // A percent sign in plain mode opens an escape unless the string ends.
  a_percent_opens: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && phase_r == upd_pkg::PH_PLAIN && item.data == upd_pkg::PERCENT
    && !item.last |=> phase_r == upd_pkg::PH_HIGH)
    else $error("percent sign did not open an escape");

  // A result without a decoded byte carries a zero byte.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !res.valid |-> res.data == 8'h00)
    else $error("result without a byte has a nonzero byte");

endmodule

// ===== src/url_percent_decoder_core.sv =====
// An item passes the input register, the single decode step, then the result register.
// Throughput: one item per cycle unless the result port stalls.
// Either register holds its item while the next stage stalls; ready follows at once.
// Reset (rst_n low, synchronous) empties both registers and returns to plain mode.
// Every input byte yields exactly one result item.
`timescale 1ns / 1ps

module url_percent_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_item_valid,
  output logic       in_item_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_item_valid,
  input  logic       out_item_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic           s1_valid_r;
  upd_pkg::item_t s1_item_r;
  logic           out_item_valid_r;
  upd_pkg::res_t  out_res_r;
  upd_pkg::res_t  res;
  logic           out_free;
  logic           s1_adv;
  logic           in_acc;

  // Flow control: each register takes a new item when it is empty or emptying.
  assign out_free      = !out_item_valid_r || out_item_ready;
  assign s1_adv        = s1_valid_r && out_free;
  assign in_item_ready = !s1_valid_r || out_free;
  assign in_acc        = in_item_valid && in_item_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_item_ready) begin
      s1_valid_r <= in_item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.data <= in_byte;
      s1_item_r.last <= in_last;
    end
  end

  // Decode step with the escape state.
  upd_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .item    (s1_item_r),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_item_valid_r <= 1'b0;
    end else if (out_free) begin
      out_item_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_item_valid = out_item_valid_r;
  assign out_valid      = out_res_r.valid;
  assign out_byte       = out_res_r.data;
  assign out_last       = out_res_r.last;

endmodule
